/* sv/b85_dec_pkg.sv */
package b85_dec_pkg;

  localparam logic [6:0] B85_RADIX     = 7'h55;
  localparam logic [6:0] B85_PAD_DIGIT = 7'h7e;
  localparam logic [6:0] B85_NO_DIGIT  = 7'h56;

  // digits per full group
  localparam logic [2:0] GROUP_DIGITS = 3'd5;

  localparam int QUEUE_DEPTH_DEF = 4;

  // pad constants: p pad digits turn acc into acc * 85^p + 126 * (1 + 85 + ... + 85^(p-1))
  // products are formed at int width so no partial product is cut to 7 bits
  localparam int RADIX_I = int'(B85_RADIX);
  localparam int PAD_I   = int'(B85_PAD_DIGIT);

  localparam logic [19:0] PAD_MULT_1 = 20'(RADIX_I);
  localparam logic [19:0] PAD_MULT_2 = 20'(RADIX_I * RADIX_I);
  localparam logic [19:0] PAD_MULT_3 = 20'(RADIX_I * RADIX_I * RADIX_I);
  localparam logic [19:0] PAD_ADD_1  = 20'(PAD_I);
  localparam logic [19:0] PAD_ADD_2  = 20'(PAD_I * (RADIX_I + 1));
  localparam logic [19:0] PAD_ADD_3  =
      20'(PAD_I * (RADIX_I * RADIX_I + RADIX_I + 1));

  // One word to unpack: bytes to emit minus one (0..3); pad digits = 3 - nbytes_m1
  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  nbytes_m1;
  } b85_job_t;

  function automatic logic [6:0] b85_digit(input logic [7:0] ch);
    logic [6:0] d;
    d = B85_NO_DIGIT;
    case (ch) inside
      [8'h30:8'h39]: d = 7'(ch - 8'h30);  // 0-9
      [8'h41:8'h5a]: d = 7'(ch - 8'd55);  // A-Z
      [8'h61:8'h7a]: d = 7'(ch - 8'd61);  // a-z
      8'h21: d = 7'd62;  // !
      8'h23: d = 7'd63;  // #
      8'h24: d = 7'd64;  // $
      8'h25: d = 7'd65;  // %
      8'h26: d = 7'd66;  // &
      8'h28: d = 7'd67;  // (
      8'h29: d = 7'd68;  // )
      8'h2a: d = 7'd69;  // *
      8'h2b: d = 7'd70;  // +
      8'h2d: d = 7'd71;  // -
      8'h3b: d = 7'd72;  // ;
      8'h3c: d = 7'd73;  // <
      8'h3d: d = 7'd74;  // =
      8'h3e: d = 7'd75;  // >
      8'h3f: d = 7'd76;  // ?
      8'h40: d = 7'd77;  // @
      8'h5e: d = 7'd78;  // ^
      8'h5f: d = 7'd79;  // _
      8'h60: d = 7'd80;  // `
      8'h7b: d = 7'd81;  // {
      8'h2f: d = 7'd82;  // /
      8'h7d: d = 7'd83;  // }
      8'h7e: d = 7'd84;  // ~
      default: d = B85_NO_DIGIT;
    endcase
    return d;
  endfunction

  function automatic logic [19:0] pad_mult(input logic [1:0] pads);
    logic [19:0] m;
    case (pads)
      2'd0:    m = 20'd1;
      2'd1:    m = PAD_MULT_1;
      2'd2:    m = PAD_MULT_2;
      2'd3:    m = PAD_MULT_3;
      default: m = 20'd1;
    endcase
    return m;
  endfunction

  function automatic logic [19:0] pad_add(input logic [1:0] pads);
    logic [19:0] a;
    case (pads)
      2'd0:    a = 20'd0;
      2'd1:    a = PAD_ADD_1;
      2'd2:    a = PAD_ADD_2;
      2'd3:    a = PAD_ADD_3;
      default: a = 20'd0;
    endcase
    return a;
  endfunction

endpackage

/* sv/b85_dec_front.sv */
module b85_dec_front
  import b85_dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_char,
  input  logic       end_of_text,
  output logic       push,
  output b85_job_t   push_job,
  output logic [2:0] digit_count
);

  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [2:0]  cnt;
  logic [2:0]  cnt_next;
  logic [6:0]  digit;
  logic        is_digit;
  logic [31:0] acc_step;
  logic [2:0]  cnt_step;

  assign digit    = b85_digit(text_char);
  assign is_digit = digit < B85_RADIX;
  assign acc_step = acc * 32'(B85_RADIX) + 32'(digit);
  assign cnt_step = cnt + 3'd1;

  always_comb begin
    acc_next = acc;
    cnt_next = cnt;
    push     = 1'b0;
    push_job.word      = acc_step;
    push_job.nbytes_m1 = 2'd3;
    if (accept) begin
      if (is_digit && cnt_step == GROUP_DIGITS) begin
        push     = 1'b1;
        acc_next = '0;
        cnt_next = '0;
      end else if (end_of_text) begin
        // partial group: k digits give k-1 bytes, a lone digit gives none
        push_job.word      = is_digit ? acc_step : acc;
        push_job.nbytes_m1 = is_digit ? 2'(cnt - 3'd1) : 2'(cnt - 3'd2);
        push     = is_digit ? (cnt_step >= 3'd2) : (cnt >= 3'd2);
        acc_next = '0;
        cnt_next = '0;
      end else if (is_digit) begin
        acc_next = acc_step;
        cnt_next = cnt_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  assign digit_count = cnt;

endmodule

/* sv/b85_dec_queue.sv */
module b85_dec_queue
  import b85_dec_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  b85_job_t push_job,
  input  logic     pop,
  output b85_job_t head_job,
  output logic     full,
  output logic     empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  b85_job_t            mem [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign full     = count == CntW'(DEPTH);
  assign empty    = count == '0;
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/b85_dec_back.sv */
module b85_dec_back
  import b85_dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  b85_job_t   head_job,
  input  logic       empty,
  output logic       pop,
  output logic       byte_valid,
  input  logic       byte_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  logic [31:0] word;
  logic [1:0]  remain;
  logic        busy;
  logic        out_take;
  logic [1:0]  pads;
  logic [51:0] product;
  logic [31:0] padded;

  // pad the word of a short final group
  assign pads    = 2'(2'd3 - head_job.nbytes_m1);
  assign product = 52'(head_job.word) * 52'(pad_mult(pads));
  assign padded  = product[31:0] + 32'(pad_add(pads));

  assign out_take = busy && !byte_stall;
  assign pop      = !empty && (!busy || (out_take && remain == 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (out_take && remain == 2'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word   <= padded;
      remain <= head_job.nbytes_m1;
    end else if (out_take) begin
      word   <= {word[23:0], 8'h00};
      remain <= remain - 2'd1;
    end
  end

  assign byte_valid  = busy;
  assign out_byte    = word[31:24];
  assign last_of_run = remain == 2'd0;

endmodule

/* sv/base85_stream_decoder.sv */
// Channel   Handshake                Payload
// char      char_valid / char_stall  text_char[7:0], end_of_text
// byte      byte_valid / byte_stall  out_byte[7:0], last_of_run
//
// One character per cycle is taken while the job queue has room.
// A full group gives one job, unpacked at one byte per cycle while byte_stall is low.
// The end of text pads a partial group in the unpack stage (one multiply).
// Reset (rst, synchronous) clears the digit group, the queue and the output.
// char_stall rises only when the queue is full; byte_stall just holds the byte.
module base85_stream_decoder
  import b85_dec_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] text_char,
  input  logic       end_of_text,
  output logic       byte_valid,
  input  logic       byte_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  logic       char_take;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  b85_job_t   push_job;
  b85_job_t   head_job;
  logic [2:0] digit_count;

  // front takes a char whenever the queue can hold a job it might make
  assign char_stall = q_full;
  assign char_take  = char_valid && !q_full;

  b85_dec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (char_take),
    .text_char   (text_char),
    .end_of_text (end_of_text),
    .push        (push),
    .push_job    (push_job),
    .digit_count (digit_count)
  );

  b85_dec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back unpacks one job at a time, MSB first
  b85_dec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .empty       (q_empty),
    .pop         (pop),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("job popped from empty queue");

  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= 3'd4)
    else $error("digit group overflow");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (char_take && end_of_text) |=> digit_count == 3'd0)
    else $error("group not cleared at end of text");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> byte_valid)
    else $error("loaded job not presented");
`endif

endmodule

/* bench/tb.sv */
module tb;
  import b85_dec_pkg::*;

  localparam int RESET_CYCLES = 11;
  // receiver hold-off long enough to fill the job queue and stall the input
  localparam int HOLD_CYCLES = 300;
  // cycles with no item moving on either channel before the run is called hung
  localparam int IDLE_LIMIT = 3000;
  // settle time after the last expected byte, to catch stray extra bytes
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 470;
  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] BACKTICK = 8'h60;

  // one decoded byte as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic [7:0] text_char = 8'h00;
  logic       end_of_text = 1'b0;
  logic       byte_stall = 1'b0;
  logic       char_stall;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       last_of_run;

  base85_stream_decoder uut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .text_char  (text_char),
    .end_of_text(end_of_text),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Decoder model: own copy of the digit group, expected bytes in order.
  // ---------------------------------------------------------------------

  // Symbol table, digit value = position. The backtick (digit 80) is kept
  // out of the string literal and handled on its own.
  string symbols_head = {"0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                         "abcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_"};
  string symbols_tail = "{/}~";

  logic [31:0] group_word = '0;    // digits folded so far, mod 2^32
  int          group_len = 0;      // digits held in the current group
  dec_byte_t   pending_bytes[$];   // decoded bytes not yet seen at the output

  int  errors = 0;
  bit  idle_en = 1'b1;     // random gaps/stalls on both sides when set
  bit  hold_req = 1'b0;    // ask the receiver for one long hold-off
  bit  hold_active = 1'b0;

  function automatic logic [7:0] symbol_char(int idx);
    if (idx < 80) return symbols_head[idx];
    if (idx == 80) return BACKTICK;
    return symbols_tail[idx - 81];
  endfunction

  // digit value of a character, -1 when it is skipped
  function automatic int symbol_value(logic [7:0] ch);
    if (ch[7]) return -1;
    for (int i = 0; i < int'(B85_RADIX); i++) begin
      if (symbol_char(i) == ch) return i;
    end
    return -1;
  endfunction

  // byte k of a word, most significant first
  function automatic void push_byte(logic [31:0] w, int k, bit last);
    dec_byte_t e;
    e.data = 8'(w >> (24 - 8 * k));
    e.last = last;
    pending_bytes.push_back(e);
  endfunction

  // Advance the model by one accepted character.
  function automatic void decode_char(logic [7:0] ch, logic eot);
    int          v;
    int          n;
    logic [31:0] w;
    v = symbol_value(ch);
    if (v >= 0) begin
      group_word = group_word * 32'(B85_RADIX) + 32'(v);
      group_len++;
      // fifth digit flushes the group, end flag or not
      if (group_len == int'(GROUP_DIGITS)) begin
        for (int k = 0; k < 4; k++) push_byte(group_word, k, k == 3);
        group_word = '0;
        group_len = 0;
        return;
      end
    end
    if (!eot) return;
    // end of text: pad a partial group with the high pad digit, keep k-1 bytes
    n = group_len;
    w = group_word;
    group_word = '0;
    group_len = 0;
    if (n < 2) return;
    for (int i = n; i < int'(GROUP_DIGITS); i++) w = w * 32'(B85_RADIX) + 32'(B85_PAD_DIGIT);
    for (int k = 0; k < n - 1; k++) push_byte(w, k, k == n - 2);
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("tb: %0t: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------
  // Output check: every accepted byte against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : byte_check
    dec_byte_t e;
    if (!rst && byte_valid && !byte_stall) begin
      if (pending_bytes.size() == 0) begin
        note_error($sformatf("byte %02h last %0b with nothing expected",
                             out_byte, last_of_run));
      end else begin
        e = pending_bytes.pop_front();
        if (out_byte !== e.data)
          note_error($sformatf("out_byte expected %02h got %02h", e.data, out_byte));
        if (last_of_run !== e.last)
          note_error($sformatf("last_of_run expected %0b got %0b (byte %02h)",
                               e.last, last_of_run, e.data));
      end
    end
  end

  // Hang detector: counts cycles with no item moving on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (byte_valid && !byte_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: no item moved for %0d cycles", IDLE_LIMIT);
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall stretches, mostly short, now and then long;
  // one long hold-off on request.
  // ---------------------------------------------------------------------
  initial begin
    int n;
    bit s;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        s = 1'b1;
        n = HOLD_CYCLES;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        hold_active = 1'b0;
        s = 1'b1;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end else begin
        hold_active = 1'b0;
        s = 1'b0;
        n = $urandom_range(1, 8);
      end
      byte_stall <= s;
      repeat (n) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, hold it until taken, then update the model.
  task automatic send_char(logic [7:0] ch, logic eot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    text_char <= ch;
    end_of_text <= eot;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    decode_char(ch, eot);
  endtask

  task automatic send_text(string s, bit eot_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eot_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] random_symbol();
    return symbol_char($urandom_range(0, int'(B85_RADIX) - 1));
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // all-zero group, closed by its own end flag on the fifth digit
  task automatic test_full_groups();
    send_text("0000", 1'b0);
    send_char("0", 1'b1);
  endtask

  // top-bit bytes inside a group of max digits; the word wraps past 2^32
  task automatic test_skipped_chars();
    send_text("~~~", 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h80, 1'b0);
    send_text("~~", 1'b0);
  endtask

  // end of text with 2, 3, 4, 1 and 0 digits held
  task automatic test_partial_ends();
    send_text("ab", 1'b0);
    send_char(" ", 1'b1);   // skipped char still ends the text
    send_text("xyz", 1'b1);
    send_text("{/}", 1'b0);
    send_char(BACKTICK, 1'b1);
    send_char("Q", 1'b1);   // lone digit: nothing out
    send_char(8'h7f, 1'b1); // empty group: nothing out
  endtask

  // Receiver holds off while the sender keeps offering back-to-back groups.
  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_req = 1'b1;
    wait (hold_active);
    for (int g = 0; g < 12; g++) begin
      for (int i = 0; i < 5; i++) send_char(random_symbol(), g == 11 && i == 4);
    end
    idle_en = 1'b1;
  endtask

  // Mostly well-formed texts with some junk mixed in, plus pure noise bursts.
  task automatic test_random_streams();
    int         counted;
    int         len;
    logic [7:0] ch;
    logic       eot;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      idle_en = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          ch = 8'($urandom_range(0, 255));
          eot = 1'($urandom_range(0, 1));
          if (symbol_value(ch) >= 0 || eot) counted++;
          send_char(ch, eot);
        end
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 15);
        for (int i = 0; i < len; i++) begin
          ch = ($urandom_range(0, 99) < 88) ? random_symbol() : 8'($urandom_range(0, 255));
          eot = (i == len - 1);
          if (symbol_value(ch) >= 0 || eot) counted++;
          send_char(ch, eot);
        end
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_full_groups();
    test_skipped_chars();
    test_partial_ends();
    test_backpressure();
    test_random_streams();

    char_valid <= 1'b0;
    // wait for every expected byte; the hang detector bounds this
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/b85_dec_pkg.sv
sv/b85_dec_front.sv
sv/b85_dec_queue.sv
sv/b85_dec_back.sv
sv/base85_stream_decoder.sv
bench/tb.sv
